// ===== rtl/core/sat_pkg.sv =====
// Shared types and constants for the summed-area table engine.
// No dependencies; used by sat_alu, summed_area_table_engine_core and the testbench.
package sat_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_VALUE_BITS = 16;
    localparam int DEF_SUM_BITS   = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int GRID_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_BUILD   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_PHASE = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_BLD_RDA,
        ST_BLD_RDU,
        ST_BLD_WR,
        ST_QRY,
        ST_QRY_END
    } t_state;

endpackage

// ===== rtl/core/sat_ram.sv =====
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sat_alu.sv =====
// Shared add/subtract unit, wraps at WIDTH bits.
// Depends on sat_pkg.
module sat_alu #(
    parameter int WIDTH = 32
) (
    input  sat_pkg::t_alu_op  i_op,
    input  logic [WIDTH-1:0]  i_a,
    input  logic [WIDTH-1:0]  i_b,
    output logic [WIDTH-1:0]  o_y
);

    always_comb begin
        case (i_op)
            sat_pkg::ALU_ADD: o_y = i_a + i_b;
            sat_pkg::ALU_SUB: o_y = i_a - i_b;
            default:          o_y = i_a + i_b;
        endcase
    end

endmodule

// ===== rtl/core/summed_area_table_engine_core.sv =====
// Top level of the summed-area table engine: APB registers, sequencer, store.
// Depends on sat_pkg, sat_ram, sat_alu.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+--------------------------------
//  command  | in        | start & !busy                  | operation, row, col, value,
//           |           |                                | row_end, col_end
//  result   | out       | o_result_valid, one cycle      | o_area_sum, o_status
//  config   | in/out    | psel & penable (pready = 1)    | paddr, pwdata, prdata
//
// Each transaction but an error holds busy until it is done; the single port of the
// store (one access a cycle, registered read) sets the pace of each one.
// After reset the store is cleared cell by cell with busy high;
// register writes are taken meanwhile.
// An error result shows in the cycle after the accept, any other in the cycle in
// which busy drops; the receiver cannot stall.
module summed_area_table_engine_core #(
    parameter int MAX_ROWS   = sat_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = sat_pkg::DEF_MAX_COLS,
    parameter int VALUE_BITS = sat_pkg::DEF_VALUE_BITS,
    parameter int SUM_BITS   = sat_pkg::DEF_SUM_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command
    input  logic                                start,
    output logic                                busy,
    input  logic [sat_pkg::OP_W-1:0]            i_operation,
    input  logic [sat_pkg::COORD_W-1:0]         i_row,
    input  logic [sat_pkg::COORD_W-1:0]         i_col,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    input  logic [sat_pkg::COORD_W-1:0]         i_row_end,
    input  logic [sat_pkg::COORD_W-1:0]         i_col_end,
    // result
    output logic                                o_result_valid,
    output logic signed [SUM_BITS-1:0]          o_area_sum,
    output logic [sat_pkg::STATUS_W-1:0]        o_status,
    // config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sat_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sat_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sat_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int EXT_W  = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;
    localparam int GW     = sat_pkg::GRID_W;
    localparam int CW     = sat_pkg::COORD_W;

    // query terms, issued in this order
    localparam logic [1:0] Q_CORNER = 2'd0;
    localparam logic [1:0] Q_ABOVE  = 2'd1;
    localparam logic [1:0] Q_LEFT   = 2'd2;
    localparam logic [1:0] Q_DIAG   = 2'd3;

    sat_pkg::t_state  r_state, n_state;
    sat_pkg::t_status r_status, n_status;

    logic [GW-1:0]       r_grid_rows, r_grid_cols;
    logic [GW-1:0]       eff_rows, eff_cols;
    logic                r_built, n_built;
    logic                r_valid, n_valid;
    logic [SUM_BITS-1:0] r_sum, n_sum;
    logic [SUM_BITS-1:0] r_acc, n_acc;
    logic [GW-1:0]       r_br, n_br, r_bc, n_bc;
    logic [1:0]          r_k, n_k;
    logic [ADDR_W-1:0]   r_clr_idx, n_clr_idx;
    logic                r_clr_reply, n_clr_reply;

    logic [CW-1:0]                r_row, r_col, r_row_end, r_col_end;
    logic signed [VALUE_BITS-1:0] r_value;

    logic                 accept;
    logic                 cfg_wr;
    logic signed [EXT_W-1:0] value_wide;
    logic [SUM_BITS-1:0]  value_sum;
    logic [GW-1:0]        row_up, col_left;
    logic                 add_bad, qry_bad;
    logic [1:0]           q_term;
    logic                 q_incl, q_sub;

    logic                 mem_en, mem_we, use_clr;
    logic [GW-1:0]        sel_row, sel_col;
    logic [ADDR_W-1:0]    mem_addr;
    logic [SUM_BITS-1:0]  mem_wdata, mem_rdata;

    sat_pkg::t_alu_op     alu_op;
    logic [SUM_BITS-1:0]  alu_a, alu_b, alu_y;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= sat_pkg::GRID_RESET;
            r_grid_cols <= sat_pkg::GRID_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                sat_pkg::REG_GRID_ROWS: r_grid_rows <= pwdata[GW-1:0];
                sat_pkg::REG_GRID_COLS: r_grid_cols <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sat_pkg::REG_GRID_ROWS:
                prdata = {{(sat_pkg::APB_DATA_W-GW){1'b0}}, r_grid_rows};
            default:
                prdata = {{(sat_pkg::APB_DATA_W-GW){1'b0}}, r_grid_cols};
        endcase
    end

    // zero size acts as one, oversize clamps to the store
    always_comb begin
        if (r_grid_rows == '0) begin
            eff_rows = GW'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            eff_rows = GW'(MAX_ROWS);
        end else begin
            eff_rows = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            eff_cols = GW'(1);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            eff_cols = GW'(MAX_COLS);
        end else begin
            eff_cols = r_grid_cols;
        end
    end

    // ---------------- command capture ----------------
    assign busy   = (r_state != sat_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row     <= i_row;
            r_col     <= i_col;
            r_row_end <= i_row_end;
            r_col_end <= i_col_end;
            r_value   <= i_value;
        end
    end

    assign value_wide = EXT_W'(r_value);
    assign value_sum  = value_wide[SUM_BITS-1:0];

    assign add_bad = ({1'b0, i_row} >= eff_rows) || ({1'b0, i_col} >= eff_cols);
    assign qry_bad = ({1'b0, i_row_end} >= eff_rows) || ({1'b0, i_col_end} >= eff_cols)
                  || (i_row > i_row_end) || (i_col > i_col_end);

    // one above / one left of the query corner, clamped at the edge
    assign row_up   = (r_row == '0) ? '0 : {1'b0, r_row} - GW'(1);
    assign col_left = (r_col == '0) ? '0 : {1'b0, r_col} - GW'(1);

    // term whose read data is on mem_rdata this cycle
    assign q_term = (r_state == sat_pkg::ST_QRY_END) ? Q_DIAG : r_k - 2'd1;

    always_comb begin
        case (q_term)
            Q_CORNER: begin q_incl = 1'b1;                     q_sub = 1'b0; end
            Q_ABOVE:  begin q_incl = (r_row != '0);             q_sub = 1'b1; end
            Q_LEFT:   begin q_incl = (r_col != '0);             q_sub = 1'b1; end
            default:  begin q_incl = (r_row != '0) && (r_col != '0); q_sub = 1'b0; end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sat_pkg::ST_CLEAR;
            r_built     <= 1'b0;
            r_valid     <= 1'b0;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_k         <= '0;
            r_br        <= '0;
            r_bc        <= '0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_valid     <= n_valid;
            r_clr_idx   <= n_clr_idx;
            r_clr_reply <= n_clr_reply;
            r_k         <= n_k;
            r_br        <= n_br;
            r_bc        <= n_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_valid     = 1'b0;
        n_sum       = '0;
        n_status    = sat_pkg::STAT_OK;
        n_acc       = r_acc;
        n_br        = r_br;
        n_bc        = r_bc;
        n_k         = r_k;
        n_clr_idx   = r_clr_idx;
        n_clr_reply = r_clr_reply;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        use_clr     = 1'b0;
        sel_row     = '0;
        sel_col     = '0;
        mem_wdata   = alu_y;
        alu_op      = sat_pkg::ALU_ADD;
        alu_a       = r_acc;
        alu_b       = mem_rdata;

        case (r_state)
            sat_pkg::ST_CLEAR: begin
                use_clr   = 1'b1;
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + ADDR_W'(1);
                if (r_clr_idx == ADDR_W'(CELLS - 1)) begin
                    n_clr_idx   = '0;
                    n_state     = sat_pkg::ST_IDLE;
                    n_valid     = r_clr_reply;
                    n_clr_reply = 1'b0;
                end
            end

            sat_pkg::ST_IDLE: begin
                if (start) begin
                    case (sat_pkg::t_op'(i_operation))
                        sat_pkg::OP_ADD: begin
                            if (r_built) begin
                                n_valid  = 1'b1;
                                n_status = sat_pkg::STAT_PHASE;
                            end else if (add_bad) begin
                                n_valid  = 1'b1;
                                n_status = sat_pkg::STAT_RANGE;
                            end else begin
                                n_state = sat_pkg::ST_ADD_RD;
                            end
                        end
                        sat_pkg::OP_BUILD: begin
                            if (r_built) begin
                                n_valid  = 1'b1;
                                n_status = sat_pkg::STAT_PHASE;
                            end else begin
                                n_br    = '0;
                                n_bc    = '0;
                                n_acc   = '0;
                                n_state = sat_pkg::ST_BLD_RDA;
                            end
                        end
                        sat_pkg::OP_QUERY: begin
                            if (!r_built) begin
                                n_valid  = 1'b1;
                                n_status = sat_pkg::STAT_PHASE;
                            end else if (qry_bad) begin
                                n_valid  = 1'b1;
                                n_status = sat_pkg::STAT_RANGE;
                            end else begin
                                n_k     = Q_CORNER;
                                n_acc   = '0;
                                n_state = sat_pkg::ST_QRY;
                            end
                        end
                        default: begin
                            n_built     = 1'b0;
                            n_clr_idx   = '0;
                            n_clr_reply = 1'b1;
                            n_state     = sat_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end

            sat_pkg::ST_ADD_RD: begin
                mem_en  = 1'b1;
                sel_row = {1'b0, r_row};
                sel_col = {1'b0, r_col};
                n_state = sat_pkg::ST_ADD_WR;
            end

            sat_pkg::ST_ADD_WR: begin
                alu_a   = mem_rdata;
                alu_b   = value_sum;
                mem_en  = 1'b1;
                mem_we  = 1'b1;
                sel_row = {1'b0, r_row};
                sel_col = {1'b0, r_col};
                n_valid = 1'b1;
                n_state = sat_pkg::ST_IDLE;
            end

            // P(r,c) = P(r-1,c) + running row sum; r_acc holds the row sum
            sat_pkg::ST_BLD_RDA: begin
                mem_en  = 1'b1;
                sel_row = r_br;
                sel_col = r_bc;
                n_state = sat_pkg::ST_BLD_RDU;
            end

            sat_pkg::ST_BLD_RDU: begin
                n_acc   = alu_y;
                mem_en  = 1'b1;
                sel_row = (r_br == '0) ? '0 : r_br - GW'(1);
                sel_col = r_bc;
                n_state = sat_pkg::ST_BLD_WR;
            end

            sat_pkg::ST_BLD_WR: begin
                alu_b   = (r_br == '0) ? '0 : mem_rdata;
                mem_en  = 1'b1;
                mem_we  = 1'b1;
                sel_row = r_br;
                sel_col = r_bc;
                n_state = sat_pkg::ST_BLD_RDA;
                if (r_bc == eff_cols - GW'(1)) begin
                    n_bc  = '0;
                    n_acc = '0;
                    if (r_br == eff_rows - GW'(1)) begin
                        n_built = 1'b1;
                        n_valid = 1'b1;
                        n_state = sat_pkg::ST_IDLE;
                    end else begin
                        n_br = r_br + GW'(1);
                    end
                end else begin
                    n_bc = r_bc + GW'(1);
                end
            end

            // issue read r_k while folding in the data of read r_k-1
            sat_pkg::ST_QRY: begin
                mem_en = 1'b1;
                case (r_k)
                    Q_CORNER: begin sel_row = {1'b0, r_row_end}; sel_col = {1'b0, r_col_end}; end
                    Q_ABOVE:  begin sel_row = row_up;            sel_col = {1'b0, r_col_end}; end
                    Q_LEFT:   begin sel_row = {1'b0, r_row_end}; sel_col = col_left;          end
                    default:  begin sel_row = row_up;            sel_col = col_left;          end
                endcase
                alu_op = q_sub ? sat_pkg::ALU_SUB : sat_pkg::ALU_ADD;
                if (r_k != Q_CORNER && q_incl) begin
                    n_acc = alu_y;
                end
                n_k = r_k + 2'd1;
                if (r_k == Q_DIAG) begin
                    n_state = sat_pkg::ST_QRY_END;
                end
            end

            sat_pkg::ST_QRY_END: begin
                alu_op  = q_sub ? sat_pkg::ALU_SUB : sat_pkg::ALU_ADD;
                n_sum   = q_incl ? alu_y : r_acc;
                n_valid = 1'b1;
                n_state = sat_pkg::ST_IDLE;
            end

            default: begin
                n_state = sat_pkg::ST_IDLE;
            end
        endcase
    end

    assign mem_addr = use_clr ? r_clr_idx
                    : ADDR_W'(32'(sel_row) * MAX_COLS + 32'(sel_col));

    sat_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    sat_alu #(
        .WIDTH (SUM_BITS)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign o_result_valid = r_valid;
    assign o_area_sum     = r_sum;
    assign o_status       = r_status;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for summed_area_table_engine_core: directed and random
// command streams, APB grid setup, a behavioral prefix-sum table as predictor.
// Depends on sat_pkg and the engine RTL only.
module testbench;
    import sat_pkg::*;

    localparam int ROWS_MAX = DEF_MAX_ROWS;
    localparam int COLS_MAX = DEF_MAX_COLS;
    localparam int VAL_W = DEF_VALUE_BITS;
    localparam int SUM_W = DEF_SUM_BITS;
    localparam int CMD_TARGET = 430;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_SHOWN = 10;
    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam logic [GRID_W-1:0] SIZE_EDGES [4] = '{7'd0, 7'd1, 7'd64, 7'd127};

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   value;
        logic [COORD_W-1:0] row_end;
        logic [COORD_W-1:0] col_end;
    } t_sat_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum;
        t_status          status;
    } t_sat_res;

    localparam int CMD_W = $bits(t_sat_cmd);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_operation = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic [COORD_W-1:0]    i_col = '0;
    logic [VAL_W-1:0]      i_value = '0;
    logic [COORD_W-1:0]    i_row_end = '0;
    logic [COORD_W-1:0]    i_col_end = '0;
    logic                  o_result_valid;
    logic [SUM_W-1:0]      o_area_sum;
    logic [STATUS_W-1:0]   o_status;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    summed_area_table_engine_core u_dut (.*);

    // predictor state
    logic [SUM_W-1:0] area_table [ROWS_MAX*COLS_MAX] = '{default: '0};
    bit               table_built = 1'b0;
    logic [GRID_W-1:0] rows_reg = GRID_RESET;
    logic [GRID_W-1:0] cols_reg = GRID_RESET;

    t_sat_cmd pending_cmds[$];
    t_sat_res expected_results[$];
    t_sat_cmd cmd_on_port;
    int burst_left = 1;
    int gap_left = 0;
    int err_count = 0;
    int cmds_queued = 0;
    int grid_setups = 0;
    int op_count [4] = '{default: 0};
    int status_count [3] = '{default: 0};

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("testbench: errors");
        $finish;
    end

    function automatic void note_error(string msg);
        if (err_count < MAX_SHOWN) $display("mismatch: %s", msg);
        err_count++;
    endfunction

    // size register as the engine uses it: zero acts as one, clamp at the maximum
    function automatic int span(logic [GRID_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    // prefix entry; anything above or left of the grid reads as zero
    function automatic logic [SUM_W-1:0] table_at(int r, int c);
        if (r < 0 || c < 0) return '0;
        return area_table[r*COLS_MAX + c];
    endfunction

    task automatic table_apply(input t_sat_cmd cmd, output t_sat_res res);
        int rows, cols, r0, c0, r1, c1, r, c;
        rows = span(rows_reg, ROWS_MAX);
        cols = span(cols_reg, COLS_MAX);
        r0 = cmd.row;
        c0 = cmd.col;
        r1 = cmd.row_end;
        c1 = cmd.col_end;
        res.area_sum = '0;
        res.status = STAT_OK;
        case (cmd.op)
            OP_ADD: begin
                if (table_built) res.status = STAT_PHASE;
                else if (r0 >= rows || c0 >= cols) res.status = STAT_RANGE;
                else area_table[r0*COLS_MAX + c0] += {{(SUM_W-VAL_W){cmd.value[VAL_W-1]}},
                                                      cmd.value};
            end
            OP_BUILD: begin
                if (table_built) res.status = STAT_PHASE;
                else begin
                    for (r = 0; r < rows; r++)
                        for (c = 0; c < cols; c++)
                            area_table[r*COLS_MAX + c] = table_at(r, c) + table_at(r-1, c)
                                + table_at(r, c-1) - table_at(r-1, c-1);
                    table_built = 1'b1;
                end
            end
            OP_QUERY: begin
                if (!table_built) res.status = STAT_PHASE;
                else if (r1 >= rows || c1 >= cols || r0 > r1 || c0 > c1) res.status = STAT_RANGE;
                else res.area_sum = table_at(r1, c1) - table_at(r0-1, c1)
                                  - table_at(r1, c0-1) + table_at(r0-1, c0-1);
            end
            default: begin
                foreach (area_table[i]) area_table[i] = '0;
                table_built = 1'b0;
            end
        endcase
    endtask

    // command driver: bursts of back-to-back transactions with random gaps
    always @(posedge i_clk) begin : cmd_driver
        t_sat_res res;
        bit slot_free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            slot_free = !start || !busy;
            if (start && !busy) begin
                table_apply(cmd_on_port, res);
                expected_results.push_back(res);
                op_count[cmd_on_port.op]++;
            end
            if (slot_free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd_on_port = pending_cmds.pop_front();
                    i_operation <= cmd_on_port.op;
                    i_row <= cmd_on_port.row;
                    i_col <= cmd_on_port.col;
                    i_value <= cmd_on_port.value;
                    i_row_end <= cmd_on_port.row_end;
                    i_col_end <= cmd_on_port.col_end;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_sat_res want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                note_error($sformatf("result with none pending: sum %0d status %0d",
                                     $signed(o_area_sum), o_status));
            end else begin
                want = expected_results.pop_front();
                if (o_area_sum !== want.area_sum || o_status !== want.status)
                    note_error($sformatf("expected sum %0d status %0d, got sum %0d status %0d",
                                         $signed(want.area_sum), want.status,
                                         $signed(o_area_sum), o_status));
                else status_count[want.status]++;
            end
        end
    end

    function automatic void push_add(int r, int c, logic [VAL_W-1:0] v);
        t_sat_cmd cmd;
        cmd.op = OP_ADD;
        cmd.row = COORD_W'(r);
        cmd.col = COORD_W'(c);
        cmd.value = v;
        cmd.row_end = COORD_W'($urandom);
        cmd.col_end = COORD_W'($urandom);
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endfunction

    function automatic void push_query(int r0, int c0, int r1, int c1);
        t_sat_cmd cmd;
        cmd.op = OP_QUERY;
        cmd.row = COORD_W'(r0);
        cmd.col = COORD_W'(c0);
        cmd.value = VAL_W'($urandom);
        cmd.row_end = COORD_W'(r1);
        cmd.col_end = COORD_W'(c1);
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endfunction

    // build and restart ignore every field but the operation
    function automatic void push_op(t_op op);
        t_sat_cmd cmd;
        cmd = t_sat_cmd'(CMD_W'({$urandom, $urandom}));
        cmd.op = op;
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(VAL_W-1){1'b0}}};
            1: return {1'b0, {(VAL_W-1){1'b1}}};
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy);
    endtask

    task automatic apb_access(input bit wr, input logic reg_sel,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_ADDR_W'({reg_sel, 2'b00});
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        rdata = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // write both size registers (junk in the unused upper bits) and read them back
    task automatic set_grid(input logic [GRID_W-1:0] rows_val, input logic [GRID_W-1:0] cols_val);
        logic [APB_DATA_W-1:0] word, rd;
        logic [GRID_W-1:0] vals [2];
        logic sel;
        int i;
        vals[0] = rows_val;
        vals[1] = cols_val;
        for (i = 0; i < 2; i++) begin
            sel = (i == 1) ? REG_GRID_COLS : REG_GRID_ROWS;
            word = $urandom;
            word[GRID_W-1:0] = vals[i];
            apb_access(1'b1, sel, word, rd);
            apb_access(1'b0, sel, '0, rd);
            if (rd[GRID_W-1:0] !== vals[i])
                note_error($sformatf("size register %0d read %0d, wrote %0d",
                                     i, rd[GRID_W-1:0], vals[i]));
        end
        rows_reg = rows_val;
        cols_reg = cols_val;
        grid_setups++;
    endtask

    // one load/build/query round; shrink builds on a smaller grid, then queries
    // the full size so cells outside the built area come back as loaded
    task automatic random_phase(input logic [GRID_W-1:0] rows_val,
                                input logic [GRID_W-1:0] cols_val,
                                input int n_add, input int n_query, input bit shrink);
        int rows, cols, r0, c0, r1, c1, k, n;
        wait_drained();
        set_grid(rows_val, cols_val);
        rows = span(rows_val, ROWS_MAX);
        cols = span(cols_val, COLS_MAX);
        push_op(OP_RESTART);
        for (n = 0; n < n_add; n++) begin
            k = $urandom_range(0, 19);
            if (k == 0) push_query($urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 63), $urandom_range(0, 63));
            else if (k < 3) push_add($urandom_range(0, 63), $urandom_range(0, 63), rand_value());
            else push_add($urandom_range(0, rows-1), $urandom_range(0, cols-1), rand_value());
        end
        if (shrink) begin
            wait_drained();
            set_grid(GRID_W'($urandom_range(1, rows)), GRID_W'($urandom_range(1, cols)));
            push_op(OP_BUILD);
            wait_drained();
            set_grid(rows_val, cols_val);
        end else begin
            push_op(OP_BUILD);
        end
        for (n = 0; n < n_query; n++) begin
            k = $urandom_range(0, 19);
            r0 = $urandom_range(0, rows-1);
            r1 = $urandom_range(r0, rows-1);
            c0 = $urandom_range(0, cols-1);
            c1 = $urandom_range(c0, cols-1);
            case (k)
                0: push_add(r0, c0, rand_value());
                1: push_op(OP_BUILD);
                2, 3: push_query($urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom_range(0, 63));
                4: push_query(r1, c0, r0, c1);
                5: push_query(r0, c1, r1, c0);
                default: push_query(r0, c0, r1, c1);
            endcase
        end
    endtask

    initial begin : stimulus
        logic [GRID_W-1:0] rv, cv;
        int phase_no;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default 64x64 grid: phase rules, extreme values and corners
        push_query(0, 0, 63, 63);
        push_add(0, 0, 16'h7fff);
        push_add(63, 63, 16'h8000);
        push_add(0, 63, 16'h0001);
        push_add(63, 0, 16'hffff);
        push_add(0, 0, 16'h7fff);
        push_add(31, 32, 16'h5a5a);
        push_op(OP_BUILD);
        push_add(1, 1, 16'h0010);
        push_op(OP_BUILD);
        push_query(0, 0, 63, 63);
        push_query(0, 0, 0, 0);
        push_query(63, 63, 63, 63);
        push_query(0, 63, 0, 63);
        push_query(1, 1, 62, 62);
        push_query(40, 0, 39, 63);
        push_query(0, 40, 63, 39);
        push_op(OP_RESTART);
        push_query(0, 0, 0, 0);

        // small grid: coordinates just past the edge
        wait_drained();
        set_grid(7'd3, 7'd5);
        push_add(3, 0, 16'h0001);
        push_add(0, 5, 16'h0001);
        push_add(2, 4, 16'h0100);
        push_add(0, 0, 16'h8000);
        push_op(OP_BUILD);
        push_query(0, 0, 3, 4);
        push_query(0, 0, 2, 5);
        push_query(0, 0, 2, 4);

        phase_no = 0;
        while (cmds_queued < CMD_TARGET) begin
            if (phase_no == 0) begin
                rv = 7'd0;
                cv = 7'd127;
            end else if (phase_no == 1) begin
                rv = 7'd127;
                cv = 7'd1;
            end else if (phase_no == 2) begin
                rv = 7'd1;
                cv = 7'd64;
            end else if ($urandom_range(0, 11) == 0) begin
                rv = SIZE_EDGES[$urandom_range(0, 3)];
                cv = SIZE_EDGES[$urandom_range(0, 3)];
            end else begin
                rv = GRID_W'($urandom_range(1, 8));
                cv = GRID_W'($urandom_range(1, 8));
            end
            random_phase(rv, cv, $urandom_range(4, 24), $urandom_range(6, 24),
                         $urandom_range(0, 3) == 0);
            phase_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("summary: %0d commands (add %0d, build %0d, query %0d, restart %0d), %0d %s",
                 op_count[OP_ADD] + op_count[OP_BUILD] + op_count[OP_QUERY]
                 + op_count[OP_RESTART], op_count[OP_ADD], op_count[OP_BUILD],
                 op_count[OP_QUERY], op_count[OP_RESTART], grid_setups, "grid sizes");
        $display("summary: matched %0d ok, %0d wrong-phase, %0d out-of-grid; %0d failures",
                 status_count[STAT_OK], status_count[STAT_PHASE], status_count[STAT_RANGE],
                 err_count);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
